>>> src/dcc_packet_decoder_assert.svh
// ---------------------------------------------------------------------------
// dcc packet decoder assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef DCC_PACKET_DECODER_ASSERT_SVH
`define DCC_PACKET_DECODER_ASSERT_SVH

// same-cycle implication
`define DCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dcc_pkg.sv
// ---------------------------------------------------------------------------
// dcc packet decoder package
// shared types, codes and constants of the decoder
// ---------------------------------------------------------------------------
package dcc_pkg;

  localparam int RING_DEPTH_DEF = 128;

  // edge counts of the packet layout
  localparam int DATA_EDGES     = 3 * 9 * 2 - 1;
  localparam int BYTE_EDGES     = 16;
  localparam int PREAMBLE_REACH = 21;
  localparam int TOP_BIT        = 7;

  localparam int BYTE_BITS      = BYTE_EDGES / 2;
  localparam int SCAN_ENTRIES   = PREAMBLE_REACH + 2;
  localparam int SCAN_BITS      = PREAMBLE_REACH / 2 + 1;
  localparam int DEC_ENTRIES    = DATA_EDGES + 2;
  localparam int DEC_BITS       = (DATA_EDGES + 1) / 2;
  localparam int DATA_BITS      = 3 * (TOP_BIT + 1);
  localparam int ENT_W          = $clog2(DEC_ENTRIES + 1);
  localparam int BIT_W          = $clog2(DEC_BITS);
  localparam int CNT_W          = 6;

  // operation codes
  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SKEW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX = 3'd4;

  // configuration reset values
  localparam logic [31:0] ONE_MIN_RST  = 32'd52;
  localparam logic [31:0] ONE_MAX_RST  = 32'd64;
  localparam logic [30:0] ONE_SKEW_RST = 31'd6;
  localparam logic [31:0] ZERO_MIN_RST = 32'd90;
  localparam logic [31:0] ZERO_MAX_RST = 32'd10000;

  typedef enum logic [1:0] {
    PH_AWAIT    = 2'd0,
    PH_COLLECT  = 2'd1,
    PH_RECEIVED = 2'd2,
    PH_ERROR    = 2'd3
  } dcc_phase_t;

  typedef enum logic [1:0] {
    BIT_ZERO = 2'd0,
    BIT_ONE  = 2'd1,
    BIT_BAD  = 2'd2
  } dcc_bit_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SCAN_GO,
    C_SCAN_WAIT,
    C_DEC_GO,
    C_DEC_WAIT,
    C_FIN
  } dcc_ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic       push;
    logic       clr_pkt;
    logic       start_scan;
    logic       start_decode;
    logic       set_start;
    logic       commit;
    logic       out_load;
    dcc_phase_t phase;
  } dcc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
    logic fail;
    logic out_busy;
  } dcc_sts_t;

endpackage

>>> src/dcc_in_if.sv
// ---------------------------------------------------------------------------
// dcc input channel
// edge timestamp or restart transaction
// ---------------------------------------------------------------------------
interface dcc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] edge_time;

  modport source (output valid, operation, edge_time, input ready);
  modport sink (input valid, operation, edge_time, output ready);
endinterface

>>> src/dcc_out_if.sv
// ---------------------------------------------------------------------------
// dcc result channel
// decoder status and packet bytes
// ---------------------------------------------------------------------------
interface dcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] decoder_status;
  logic [7:0] address_byte;
  logic [7:0] instruction_byte;
  logic [7:0] check_byte;

  modport source (output valid, decoder_status, address_byte, instruction_byte, check_byte,
                  input ready);
  modport sink (input valid, decoder_status, address_byte, instruction_byte, check_byte,
                output ready);
endinterface

>>> src/dcc_cfg_if.sv
// ---------------------------------------------------------------------------
// dcc configuration channel
// register index and write data
// ---------------------------------------------------------------------------
interface dcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/dcc_packet_decoder.sv
// Restart and plain pushes pass from idle through the finish state to the result register.
// A push while awaiting start first streams 23 ring entries through the preamble scan.
// The push completing the data edges first streams 55 entries through the packet decode.
// Throughput: one transaction at a time; an untaken result holds off the next input.
// Reset (rst_n low, synchronous) clears control state, ring valid bits and registers.
// ---------------------------------------------------------------------------
// dcc packet decoder
// decodes baseline packets from edge timestamps held in a ring
// ---------------------------------------------------------------------------
module dcc_packet_decoder #(
  parameter int RING_DEPTH = dcc_pkg::RING_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  dcc_in_if.sink    in_ch,
  dcc_out_if.source out_ch,
  dcc_cfg_if.sink   cfg_ch
);

  dcc_pkg::dcc_cmd_t cmd;
  dcc_pkg::dcc_sts_t sts;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  // controller
  dcc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  // datapath
  dcc_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .edge_time       (in_ch.edge_time),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.decoder_status),
    .out_address     (out_ch.address_byte),
    .out_instruction (out_ch.instruction_byte),
    .out_check       (out_ch.check_byte)
  );

endmodule

>>> src/dcc_ctrl.sv
// ---------------------------------------------------------------------------
// dcc controller
// sequences push, preamble scan, packet decode and result hand-off
// ---------------------------------------------------------------------------
`include "dcc_packet_decoder_assert.svh"

module dcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_ready,
  output dcc_pkg::dcc_cmd_t cmd,
  input  dcc_pkg::dcc_sts_t sts
);

  dcc_pkg::dcc_ctl_state_t          state_r, state_nxt;
  dcc_pkg::dcc_phase_t              phase_r, phase_nxt;
  logic [dcc_pkg::CNT_W-1:0]        esc_r, esc_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcc_pkg::C_IDLE;
      phase_r <= dcc_pkg::PH_AWAIT;
      esc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.phase = phase_r;
    unique case (state_r)
      dcc_pkg::C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == dcc_pkg::OP_RESTART) begin
            phase_nxt   = dcc_pkg::PH_AWAIT;
            esc_nxt     = '0;
            cmd.clr_pkt = 1'b1;
            state_nxt   = dcc_pkg::C_FIN;
          end else begin
            cmd.push = 1'b1;
            if (phase_r == dcc_pkg::PH_AWAIT) begin
              state_nxt = dcc_pkg::C_SCAN_GO;
            end else begin
              // count saturates one past the data span
              if (esc_r <= dcc_pkg::CNT_W'(dcc_pkg::DATA_EDGES))
                esc_nxt = esc_r + 1'b1;
              if (phase_r == dcc_pkg::PH_COLLECT &&
                  esc_nxt > dcc_pkg::CNT_W'(dcc_pkg::DATA_EDGES))
                state_nxt = dcc_pkg::C_DEC_GO;
              else
                state_nxt = dcc_pkg::C_FIN;
            end
          end
        end
      end
      dcc_pkg::C_SCAN_GO: begin
        cmd.start_scan = 1'b1;
        state_nxt      = dcc_pkg::C_SCAN_WAIT;
      end
      dcc_pkg::C_SCAN_WAIT: begin
        if (sts.done) begin
          if (!sts.fail) begin
            cmd.set_start = 1'b1;
            phase_nxt     = dcc_pkg::PH_COLLECT;
            esc_nxt       = '0;
          end
          state_nxt = dcc_pkg::C_FIN;
        end
      end
      dcc_pkg::C_DEC_GO: begin
        cmd.start_decode = 1'b1;
        state_nxt        = dcc_pkg::C_DEC_WAIT;
      end
      dcc_pkg::C_DEC_WAIT: begin
        if (sts.done) begin
          if (sts.fail) begin
            phase_nxt = dcc_pkg::PH_ERROR;
          end else begin
            cmd.commit = 1'b1;
            phase_nxt  = dcc_pkg::PH_RECEIVED;
          end
          state_nxt = dcc_pkg::C_FIN;
        end
      end
      dcc_pkg::C_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = dcc_pkg::C_IDLE;
        end
      end
      default: state_nxt = dcc_pkg::C_IDLE;
    endcase
  end

  // assertion helpers
  logic acc_idle, in_wait;

  assign acc_idle = state_r == dcc_pkg::C_IDLE && in_valid && in_ready;
  assign in_wait  = state_r == dcc_pkg::C_SCAN_WAIT || state_r == dcc_pkg::C_DEC_WAIT;

  `DCC_ASSERT_NXT(a_accept_leaves_idle, acc_idle, state_r != dcc_pkg::C_IDLE, "no work started")
  `DCC_ASSERT_IMP(a_done_when_waiting, sts.done, in_wait, "walk finished outside a wait state")
  `DCC_ASSERT_IMP(a_load_into_free_slot, cmd.out_load, !sts.out_busy, "result overwritten")

endmodule

>>> src/dcc_dpath.sv
// ---------------------------------------------------------------------------
// dcc datapath
// edge ring, streaming bit classifier, packet and result registers
// ---------------------------------------------------------------------------
module dcc_dpath #(
  parameter int RING_DEPTH = dcc_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [31:0]                  edge_time,
  input  logic                         cfg_valid,
  input  logic [dcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data,
  input  dcc_pkg::dcc_cmd_t            cmd,
  output dcc_pkg::dcc_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [7:0]                   out_address,
  output logic [7:0]                   out_instruction,
  output logic [7:0]                   out_check
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW:0] DEPTH_X = (PW+1)'(RING_DEPTH);

  // position arithmetic modulo ring depth
  function automatic logic [PW-1:0] pos_sub(input logic [PW-1:0] a, input logic [PW:0] k);
    logic [PW:0] s;
    s = {1'b0, a} + DEPTH_X - k;
    if (s >= DEPTH_X)
      s = s - DEPTH_X;
    return s[PW-1:0];
  endfunction

  // configuration registers
  logic [31:0] one_min_r, one_max_r, zero_min_r, zero_max_r;
  logic [30:0] one_skew_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_min_r  <= dcc_pkg::ONE_MIN_RST;
      one_max_r  <= dcc_pkg::ONE_MAX_RST;
      one_skew_r <= dcc_pkg::ONE_SKEW_RST;
      zero_min_r <= dcc_pkg::ZERO_MIN_RST;
      zero_max_r <= dcc_pkg::ZERO_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dcc_pkg::CFG_ONE_MIN:  one_min_r  <= cfg_data;
        dcc_pkg::CFG_ONE_MAX:  one_max_r  <= cfg_data;
        dcc_pkg::CFG_ONE_SKEW: one_skew_r <= cfg_data[30:0];
        dcc_pkg::CFG_ZERO_MIN: zero_min_r <= cfg_data;
        dcc_pkg::CFG_ZERO_MAX: zero_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge ring with per-entry valid bits, unwritten entries read as zero
  logic [31:0]           ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_r;
  logic [PW-1:0]         wr_pos_r, start_pos_r;
  logic [31:0]           rd_mem_r;
  logic                  rd_hit_r;
  logic [PW-1:0]         rd_ptr_r;
  logic [dcc_pkg::ENT_W-1:0] rd_left_r;
  logic                  rv_r;
  logic [31:0]           rdata;

  always_ff @(posedge clk) begin
    if (cmd.push)
      ring_mem[wr_pos_r] <= edge_time;
    rd_mem_r <= ring_mem[rd_ptr_r];
    rd_hit_r <= ring_vld_r[rd_ptr_r];
  end

  assign rdata = rd_hit_r ? rd_mem_r : '0;

  // write pointer, start position and read stream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r  <= '0;
      wr_pos_r    <= '0;
      start_pos_r <= '0;
      rd_ptr_r    <= '0;
      rd_left_r   <= '0;
      rv_r        <= 1'b0;
    end else begin
      if (cmd.push) begin
        ring_vld_r[wr_pos_r] <= 1'b1;
        wr_pos_r <= (wr_pos_r == PW'(RING_DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
      end
      if (cmd.set_start)
        start_pos_r <= pos_sub(wr_pos_r, (PW+1)'(3));
      if (cmd.start_scan) begin
        rd_ptr_r  <= pos_sub(wr_pos_r, (PW+1)'(dcc_pkg::SCAN_ENTRIES));
        rd_left_r <= dcc_pkg::ENT_W'(dcc_pkg::SCAN_ENTRIES);
        rv_r      <= 1'b0;
      end else if (cmd.start_decode) begin
        rd_ptr_r  <= pos_sub(start_pos_r, (PW+1)'(RING_DEPTH - 2));
        rd_left_r <= dcc_pkg::ENT_W'(dcc_pkg::DEC_ENTRIES);
        rv_r      <= 1'b0;
      end else if (rd_left_r != '0) begin
        rd_ptr_r  <= (rd_ptr_r == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
        rd_left_r <= rd_left_r - 1'b1;
        rv_r      <= 1'b1;
      end else begin
        rv_r <= 1'b0;
      end
    end
  end

  // edge window and bit forming, every second entry closes a bit
  logic [31:0]               w0_r, w1_r;
  logic [dcc_pkg::ENT_W-1:0] ent_r;
  logic [dcc_pkg::BIT_W-1:0] bit_r;
  logic                      s1_v_r, s1_ord_r;
  logic [dcc_pkg::BIT_W-1:0] s1_j_r;
  logic [31:0]               s1_d1_r, s1_d2_r;
  logic                      form;

  assign form = rv_r && ent_r >= dcc_pkg::ENT_W'(2) && !ent_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r  <= '0;
      bit_r  <= '0;
      s1_v_r <= 1'b0;
    end else if (cmd.start_scan || cmd.start_decode) begin
      ent_r  <= '0;
      bit_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= form;
      if (rv_r)
        ent_r <= ent_r + 1'b1;
      if (form)
        bit_r <= bit_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rv_r) begin
      w0_r <= w1_r;
      w1_r <= rdata;
    end
    s1_j_r   <= bit_r;
    s1_ord_r <= (w0_r < w1_r) && (w1_r < rdata);
    s1_d1_r  <= w1_r - w0_r;
    s1_d2_r  <= rdata - w1_r;
  end

  // range checks and interval difference
  logic                      s2_v_r, s2_ord_r, s2_in1_r, s2_in0_r;
  logic [dcc_pkg::BIT_W-1:0] s2_j_r;
  logic [31:0]               s2_diff_r;
  logic [32:0]               d_sub;

  assign d_sub = {1'b0, s1_d1_r} - {1'b0, s1_d2_r};

  always_ff @(posedge clk) begin
    if (!rst_n)
      s2_v_r <= 1'b0;
    else
      s2_v_r <= s1_v_r && !(cmd.start_scan || cmd.start_decode);
  end

  always_ff @(posedge clk) begin
    s2_j_r    <= s1_j_r;
    s2_ord_r  <= s1_ord_r;
    s2_in1_r  <= s1_d1_r >= one_min_r && s1_d1_r <= one_max_r &&
                 s1_d2_r >= one_min_r && s1_d2_r <= one_max_r;
    s2_in0_r  <= s1_d1_r >= zero_min_r && s1_d1_r <= zero_max_r &&
                 s1_d2_r >= zero_min_r && s1_d2_r <= zero_max_r;
    s2_diff_r <= d_sub[32] ? (s1_d2_r - s1_d1_r) : d_sub[31:0];
  end

  // bit class and check against the expected layout
  dcc_pkg::dcc_bit_t         cls;
  logic                      dec_mode_r, fail_r, done_r;
  logic [dcc_pkg::DATA_BITS-1:0] data_sr_r;
  logic                      is_last, bit_bad;

  always_comb begin
    if (s2_ord_r && s2_in1_r && s2_diff_r <= {1'b0, one_skew_r})
      cls = dcc_pkg::BIT_ONE;
    else if (s2_ord_r && s2_in0_r)
      cls = dcc_pkg::BIT_ZERO;
    else
      cls = dcc_pkg::BIT_BAD;
  end

  always_comb begin
    if (dec_mode_r) begin
      is_last = s2_j_r == dcc_pkg::BIT_W'(dcc_pkg::DEC_BITS - 1);
      if (s2_j_r == dcc_pkg::BIT_W'(dcc_pkg::BYTE_BITS) ||
          s2_j_r == dcc_pkg::BIT_W'(2 * dcc_pkg::BYTE_BITS + 1))
        bit_bad = cls != dcc_pkg::BIT_ZERO;
      else if (is_last)
        bit_bad = cls != dcc_pkg::BIT_ONE;
      else
        bit_bad = cls == dcc_pkg::BIT_BAD;
    end else begin
      is_last = s2_j_r == dcc_pkg::BIT_W'(dcc_pkg::SCAN_BITS - 1);
      bit_bad = is_last ? (cls != dcc_pkg::BIT_ZERO) : (cls != dcc_pkg::BIT_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_mode_r <= 1'b0;
      fail_r     <= 1'b0;
      done_r     <= 1'b0;
    end else if (cmd.start_scan || cmd.start_decode) begin
      dec_mode_r <= cmd.start_decode;
      fail_r     <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r <= s2_v_r && is_last;
      if (s2_v_r && bit_bad)
        fail_r <= 1'b1;
    end
  end

  // data bits shift in msb first, separators skipped
  always_ff @(posedge clk) begin
    if (s2_v_r && dec_mode_r && !is_last &&
        s2_j_r != dcc_pkg::BIT_W'(dcc_pkg::BYTE_BITS) &&
        s2_j_r != dcc_pkg::BIT_W'(2 * dcc_pkg::BYTE_BITS + 1))
      data_sr_r <= {data_sr_r[dcc_pkg::DATA_BITS-2:0], cls == dcc_pkg::BIT_ONE};
  end

  // packet registers
  logic [7:0] pkt_addr_r, pkt_instr_r, pkt_check_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_pkt) begin
      pkt_addr_r  <= '0;
      pkt_instr_r <= '0;
      pkt_check_r <= '0;
    end else if (cmd.commit) begin
      pkt_addr_r  <= data_sr_r[23:16];
      pkt_instr_r <= data_sr_r[15:8];
      pkt_check_r <= data_sr_r[7:0];
    end
  end

  // result register
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_addr_r, out_instr_r, out_check_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (cmd.out_load)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.phase;
      out_addr_r   <= pkt_addr_r;
      out_instr_r  <= pkt_instr_r;
      out_check_r  <= pkt_check_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_address     = out_addr_r;
  assign out_instruction = out_instr_r;
  assign out_check       = out_check_r;

  assign sts.done     = done_r;
  assign sts.fail     = fail_r;
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

>>> bench/dcc_packet_decoder_tb.sv
// ---------------------------------------------------------------------------
// dcc packet decoder testbench
// drives edge timestamps and restarts, predicts decoder status and packet
// bytes per transaction and checks every result in order
// ---------------------------------------------------------------------------
module dcc_packet_decoder_tb;

  localparam int DEPTH     = dcc_pkg::RING_DEPTH_DEF;
  localparam int MAX_CYC   = 1500000;
  localparam int RAND_ITEMS = 850;

  typedef struct {
    dcc_pkg::dcc_phase_t status;
    logic [7:0] addr;
    logic [7:0] instr;
    logic [7:0] chk;
  } dcc_result_t;

  // decoder predictor and store of expected results
  class dcc_scoreboard;
    logic [31:0] ring [DEPTH];
    int unsigned wpos, spos, since_start;
    dcc_pkg::dcc_phase_t ph;
    logic [7:0]  p_addr, p_instr, p_chk;
    logic [31:0] one_min, one_max, zero_min, zero_max;
    logic [30:0] one_skew;
    dcc_result_t pending_q[$];
    int          errors;

    function void clear_all();
      foreach (ring[i]) ring[i] = '0;
      wpos = 0; spos = 0;
      restart_dec();
      one_min = dcc_pkg::ONE_MIN_RST; one_max = dcc_pkg::ONE_MAX_RST;
      one_skew = dcc_pkg::ONE_SKEW_RST;
      zero_min = dcc_pkg::ZERO_MIN_RST; zero_max = dcc_pkg::ZERO_MAX_RST;
      errors = 0;
    endfunction

    function void restart_dec();
      ph = dcc_pkg::PH_AWAIT; since_start = 0;
      p_addr = '0; p_instr = '0; p_chk = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        dcc_pkg::CFG_ONE_MIN:  one_min = val;
        dcc_pkg::CFG_ONE_MAX:  one_max = val;
        dcc_pkg::CFG_ONE_SKEW: one_skew = val[30:0];
        dcc_pkg::CFG_ZERO_MIN: zero_min = val;
        dcc_pkg::CFG_ZERO_MAX: zero_max = val;
        default: ;
      endcase
    endfunction

    function dcc_pkg::dcc_bit_t bit_at(int unsigned pos);
      logic [31:0] t1, t2, t3, d1, d2, df;
      t1 = ring[pos % DEPTH]; t2 = ring[(pos + 1) % DEPTH]; t3 = ring[(pos + 2) % DEPTH];
      if (t1 >= t2 || t2 >= t3) return dcc_pkg::BIT_BAD;
      d1 = t2 - t1; d2 = t3 - t2;
      df = (d1 > d2) ? d1 - d2 : d2 - d1;
      if (d1 >= one_min && d1 <= one_max && d2 >= one_min && d2 <= one_max &&
          df <= {1'b0, one_skew})
        return dcc_pkg::BIT_ONE;
      if (d1 >= zero_min && d1 <= zero_max && d2 >= zero_min && d2 <= zero_max)
        return dcc_pkg::BIT_ZERO;
      return dcc_pkg::BIT_BAD;
    endfunction

    // three bytes plus separators after the start bit
    function void unpack_frame();
      logic [7:0] b [3];
      int unsigned base;
      dcc_pkg::dcc_bit_t bt;
      base = (spos + 2) % DEPTH;
      for (int i = 0; i < 3; i++) begin
        b[i] = '0;
        for (int k = 0; k < dcc_pkg::BYTE_EDGES; k += 2) begin
          bt = bit_at(base + k);
          if (bt == dcc_pkg::BIT_BAD) begin ph = dcc_pkg::PH_ERROR; return; end
          b[i][dcc_pkg::TOP_BIT - k / 2] = (bt == dcc_pkg::BIT_ONE);
        end
        if (bit_at(base + dcc_pkg::BYTE_EDGES) !=
            ((i < 2) ? dcc_pkg::BIT_ZERO : dcc_pkg::BIT_ONE)) begin
          ph = dcc_pkg::PH_ERROR; return;
        end
        base = (base + dcc_pkg::BYTE_EDGES + 2) % DEPTH;
      end
      p_addr = b[0]; p_instr = b[1]; p_chk = b[2];
      ph = dcc_pkg::PH_RECEIVED;
    endfunction

    function void note_input(logic op, logic [31:0] t);
      int unsigned cand;
      bit ok;
      dcc_result_t r;
      if (op == dcc_pkg::OP_RESTART) restart_dec();
      else begin
        ring[wpos] = t;
        wpos = (wpos + 1) % DEPTH;
        if (ph == dcc_pkg::PH_AWAIT) begin
          cand = (wpos + DEPTH - 3) % DEPTH;
          if (bit_at(cand) == dcc_pkg::BIT_ZERO) begin
            ok = 1;
            for (int k = 2; k < dcc_pkg::PREAMBLE_REACH; k += 2)
              if (bit_at(cand + DEPTH - k) != dcc_pkg::BIT_ONE) ok = 0;
            if (ok) begin spos = cand; since_start = 0; ph = dcc_pkg::PH_COLLECT; end
          end
        end else begin
          if (since_start <= dcc_pkg::DATA_EDGES) since_start++;
          if (ph == dcc_pkg::PH_COLLECT && since_start > dcc_pkg::DATA_EDGES)
            unpack_frame();
        end
      end
      r.status = ph; r.addr = p_addr; r.instr = p_instr; r.chk = p_chk;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [7:0] a, logic [7:0] ins,
                               logic [7:0] c);
      dcc_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status) begin
        $error("decoder_status expected %0d actual %0d", e.status, st); errors++;
      end
      if (a !== e.addr) begin
        $error("address_byte expected %0h actual %0h", e.addr, a); errors++;
      end
      if (ins !== e.instr) begin
        $error("instruction_byte expected %0h actual %0h", e.instr, ins); errors++;
      end
      if (c !== e.chk) begin
        $error("check_byte expected %0h actual %0h", e.chk, c); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  dcc_in_if  in_ch ();
  dcc_out_if out_ch ();
  dcc_cfg_if cfg_ch ();

  dcc_packet_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  dcc_scoreboard sb;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  bit hold_off     = 0;
  logic [31:0] now_tick = 32'd1000;
  int cycles = 0;
  int n = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && ($urandom_range(99) >= out_idle_pct);
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.decoder_status, out_ch.address_byte,
                      out_ch.instruction_byte, out_ch.check_byte);
  end

  // one transaction, then valid is dropped while the block is busy anyway
  task automatic send_item(logic op, logic [31:0] t);
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) @(posedge clk);
    in_ch.valid <= 1'b1; in_ch.operation <= op; in_ch.edge_time <= t;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op, t);
    n++;
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic push_gap(logic [31:0] gap);
    now_tick = now_tick + gap;
    send_item(dcc_pkg::OP_PUSH, now_tick);
  endtask

  // one bit as two half intervals, optionally corrupted
  task automatic send_bit(bit b, bit noisy);
    logic [31:0] h;
    for (int i = 0; i < 2; i++) begin
      h = b ? $urandom_range(sb.one_max - sb.one_skew / 2, sb.one_min)
            : $urandom_range(sb.zero_min + 60, sb.zero_min);
      if (noisy && $urandom_range(99) < 4) h = $urandom_range(300);
      push_gap(h);
    end
  endtask

  // preamble, start bit and three bytes with separators
  task automatic send_packet(logic [7:0] a, logic [7:0] ins, logic [7:0] c, bit noisy,
                             bit bad_sep);
    logic [7:0] by [3];
    by[0] = a; by[1] = ins; by[2] = c;
    push_gap(sb.one_min);
    repeat (10 + $urandom_range(3)) send_bit(1, 0);
    send_bit(0, 0);
    for (int i = 0; i < 3; i++) begin
      for (int k = 7; k >= 0; k--) send_bit(by[i][k], noisy);
      send_bit((i == 2) ^ (bad_sep && i == 1), noisy);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.operation = dcc_pkg::OP_PUSH; in_ch.edge_time = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = dcc_pkg::CFG_ONE_MIN; cfg_ch.data = '0;
    sb = new();
    sb.clear_all();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme bytes, bad separator, short preamble, restart, wrapping time
    in_idle_pct = 18; out_idle_pct = 53;
    send_packet(8'hFF, 8'h00, 8'hA5, 0, 0);
    send_item(dcc_pkg::OP_RESTART, 32'hFFFF_FFFF);
    send_packet(8'h00, 8'hFF, 8'h5A, 0, 1);
    send_item(dcc_pkg::OP_RESTART, '0);
    push_gap(sb.one_min); repeat (5) send_bit(1, 0); send_bit(0, 0);
    push_gap(0); push_gap(32'hFFFF_FFF0);
    send_item(dcc_pkg::OP_RESTART, '0);
    drain();

    // registers at extremes
    write_cfg(dcc_pkg::CFG_ONE_MIN, 32'd0);
    write_cfg(dcc_pkg::CFG_ONE_MAX, 32'hFFFF_FFFF);
    write_cfg(dcc_pkg::CFG_ONE_SKEW, 32'hFFFF_FFFF);
    write_cfg(dcc_pkg::CFG_ZERO_MIN, 32'd0);
    write_cfg(dcc_pkg::CFG_ZERO_MAX, 32'hFFFF_FFFF);
    repeat (8) push_gap($urandom);
    send_item(dcc_pkg::OP_RESTART, '0);
    drain();
    write_cfg(dcc_pkg::CFG_ONE_MIN, 32'd20);
    write_cfg(dcc_pkg::CFG_ONE_MAX, 32'd30);
    write_cfg(dcc_pkg::CFG_ONE_SKEW, 32'd0);
    write_cfg(dcc_pkg::CFG_ZERO_MIN, 32'd40);
    write_cfg(dcc_pkg::CFG_ZERO_MAX, 32'd70);

    // random part across three idling phases
    for (int phs = 0; phs < 3; phs++) begin
      in_idle_pct  = (phs == 0) ? 18 : (phs == 1) ? 53 : 0;
      out_idle_pct = (phs == 0) ? 53 : (phs == 1) ? 18 : 0;
      if (phs == 2) begin
        drain();
        write_cfg(dcc_pkg::CFG_ONE_MIN, dcc_pkg::ONE_MIN_RST);
        write_cfg(dcc_pkg::CFG_ONE_MAX, dcc_pkg::ONE_MAX_RST);
        write_cfg(dcc_pkg::CFG_ONE_SKEW, 32'(dcc_pkg::ONE_SKEW_RST));
        write_cfg(dcc_pkg::CFG_ZERO_MIN, dcc_pkg::ZERO_MIN_RST);
        write_cfg(dcc_pkg::CFG_ZERO_MAX, dcc_pkg::ZERO_MAX_RST);
        // long receiver hold-off while items keep coming
        fork
          begin hold_off = 1; repeat (400) @(posedge clk); hold_off = 0; end
          repeat (20) push_gap($urandom_range(200));
        join
      end
      while (n < RAND_ITEMS * (phs + 1) / 3) begin
        if ($urandom_range(9) < 7) begin
          send_packet($urandom, $urandom, $urandom, $urandom_range(1),
                      $urandom_range(9) == 0);
          repeat ($urandom_range(4)) push_gap($urandom_range(120));
        end else begin
          repeat ($urandom_range(10, 1)) push_gap($urandom_range(9) == 0 ? $urandom
                                                  : $urandom_range(200));
        end
        send_item(dcc_pkg::OP_RESTART, $urandom);
      end
    end

    drain();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
